>>> design/iec_pkg.sv
// Shared types and constants for the isoline edge crossing block.
`timescale 1ns / 1ps
package iec_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int FRAC_BITS_MAX = 24;
  localparam int T_BITS = 16;
  localparam int T_W = T_BITS + 1;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_BITS;
  // Level shifted by the widest fraction minus a 32-bit coordinate, signed.
  localparam int DIFF_W = FRAC_BITS_MAX + 17;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [0:0] REG_COORD_TOL = 1'd0;
  localparam logic [0:0] REG_SNAP_TOL = 1'd1;

  // Classification of one edge as decided by the front end.
  typedef struct packed {
    logic [19:0] tri_id;
    logic [1:0]  edge_idx;
    logic        is_u;
    logic [15:0] level;
    logic        flat;
    logic        emit_a;
    logic        emit_b;
    logic [DIFF_W-1:0] num;
    logic [DIFF_W-1:0] den;
    logic [31:0] ua, va, ub, vb, xa, ya, xb, yb;
  } edge_cls_t;

  // One crossing point.
  typedef struct packed {
    logic [19:0] tri_id;
    logic [1:0]  edge_idx;
    logic        is_u;
    logic [15:0] level;
    logic [T_W-1:0] t;
    logic [31:0] x, y, u, v;
    logic        last;
  } cross_t;
endpackage

>>> design/iec_front.sv
// Front end: crossing test, flat-edge detection and divider operands.
`timescale 1ns / 1ps
module iec_front #(
  parameter int FRAC_BITS = iec_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [15:0] coord_tol,
  input  logic [19:0] triangle_id,
  input  logic [1:0]  edge_index,
  input  logic        is_u_line,
  input  logic signed [15:0] iso_level,
  input  logic signed [31:0] ua, va, ub, vb, xa, ya, xb, yb,
  output logic q_valid,
  input  logic q_ready,
  output iec_pkg::edge_cls_t q_data
);
  localparam int DW = iec_pkg::DIFF_W;
  logic signed [DW-1:0] lvl, ca, cb, da, db, dba;
  logic [DW-1:0] ada, adb, adba;
  logic hit, flat;
  iec_pkg::edge_cls_t cls;
  logic ovalid;
  iec_pkg::edge_cls_t odata;

  always_comb begin
    lvl = DW'(iso_level) <<< FRAC_BITS;
    ca = is_u_line ? DW'(ua) : DW'(va);
    cb = is_u_line ? DW'(ub) : DW'(vb);
    da = ca - lvl;
    db = cb - lvl;
    dba = cb - ca;
    ada = da[DW-1] ? -da : da;
    adb = db[DW-1] ? -db : db;
    adba = dba[DW-1] ? -dba : dba;
    hit = (da <= 0 && db >= 0) || (da >= 0 && db <= 0);
    flat = (ca == cb);
    cls.tri_id = triangle_id;
    cls.edge_idx = edge_index;
    cls.is_u = is_u_line;
    cls.level = iso_level;
    cls.flat = flat;
    cls.emit_a = ada < DW'(coord_tol);
    cls.emit_b = adb < DW'(coord_tol);
    cls.num = ada;
    cls.den = adba;
    cls.ua = ua; cls.va = va; cls.ub = ub; cls.vb = vb;
    cls.xa = xa; cls.ya = ya; cls.xb = xb; cls.yb = yb;
  end

  // Flat edges that fail tolerance give nothing; drop them here.
  logic keep;
  assign keep = hit && (!flat || cls.emit_a || cls.emit_b);
  assign in_ready = !ovalid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (in_ready) begin
      ovalid <= in_valid && keep;
    end
    if (in_ready) odata <= cls;
  end
  assign q_valid = ovalid;
  assign q_data = odata;
endmodule

>>> design/iec_back.sv
// Back end: pipelined restoring divider, snapping and interpolation.
`timescale 1ns / 1ps
module iec_back (
  input  logic clk,
  input  logic rst,
  input  logic [15:0] snap_limit,
  input  logic in_valid,
  output logic in_ready,
  input  iec_pkg::edge_cls_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output iec_pkg::cross_t out_data
);
  localparam int DW = iec_pkg::DIFF_W;
  localparam int TW = iec_pkg::T_W;
  localparam int TB = iec_pkg::T_BITS;
  // Quotient bits computed: T_BITS+1, the quotient reaches 1.0 at most.
  localparam int QB = TB + 1;
  localparam int RW = DW + 1;

  typedef struct packed {
    iec_pkg::edge_cls_t e;
    logic [RW-1:0] rem;
    logic [QB-1:0] q;
    logic second;
  } stg_t;

  // Output register; the whole pipeline advances when it can take a beat.
  logic oval;
  iec_pkg::cross_t odat;
  logic mval;
  logic adv;
  assign adv = !oval || out_ready;

  // Flat edges with two results enter as two beats; the queue entry is
  // released with the second one.
  logic two, split_phase, take;
  assign two = in_data.flat && in_data.emit_a && in_data.emit_b;
  assign take = in_valid && adv;
  assign in_ready = adv && (!two || split_phase);

  stg_t s0;
  always_comb begin
    s0.e = in_data;
    s0.second = two ? split_phase : in_data.emit_b && !in_data.emit_a;
    s0.q = '0;
    s0.rem = {1'b0, in_data.num};
  end

  always_ff @(posedge clk) begin
    if (rst) split_phase <= 1'b0;
    else if (in_valid && adv && two) split_phase <= !split_phase;
  end

  // One quotient bit per stage, MSB first; num <= den so the top bit is a
  // plain compare and later bits shift the remainder.
  function automatic stg_t div_step(stg_t s, int k);
    stg_t r;
    logic [RW-1:0] rc;
    r = s;
    rc = (k == 0) ? s.rem : {s.rem[RW-2:0], 1'b0};
    if (!s.e.flat && rc >= RW'(s.e.den)) begin
      rc = rc - RW'(s.e.den);
      r.q[QB-1-k] = 1'b1;
    end
    r.rem = rc;
    return r;
  endfunction

  logic [QB-1:0] vld;
  stg_t st [QB];
  stg_t nx [QB];
  always_comb begin
    nx[0] = div_step(s0, 0);
    for (int k = 1; k < QB; k++) nx[k] = div_step(st[k - 1], k);
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[QB-2:0], take};
    if (adv) begin
      for (int k = 0; k < QB; k++) st[k] <= nx[k];
    end
  end

  // Snap logic, combinational ahead of the multiply stage.
  stg_t sq;
  logic [TW-1:0] tq, ts;
  always_comb begin
    sq = st[QB-1];
    tq = (sq.q > QB'(iec_pkg::T_ONE)) ? iec_pkg::T_ONE : TW'(sq.q);
    ts = tq;
    if (ts < TW'(snap_limit)) ts = '0;
    if ({1'b0, ts} > ({1'b0, iec_pkg::T_ONE} - (TW + 1)'(snap_limit))) ts = iec_pkg::T_ONE;
    if (sq.e.flat) ts = sq.second ? iec_pkg::T_ONE : '0;
  end

  // Multiply stage: four products t*(b-a).
  typedef struct packed {
    iec_pkg::edge_cls_t e;
    logic [TW-1:0] t;
    logic last;
    logic signed [50:0] px, py, pu, pv;
  } mul_t;
  mul_t m;
  logic signed [32:0] dx, dy, du, dv;
  logic signed [TW:0] tsg;
  always_comb begin
    tsg = {1'b0, ts};
    dx = 33'(signed'(sq.e.xb)) - 33'(signed'(sq.e.xa));
    dy = 33'(signed'(sq.e.yb)) - 33'(signed'(sq.e.ya));
    du = 33'(signed'(sq.e.ub)) - 33'(signed'(sq.e.ua));
    dv = 33'(signed'(sq.e.vb)) - 33'(signed'(sq.e.va));
  end
  always_ff @(posedge clk) begin
    if (rst) mval <= 1'b0;
    else if (adv) mval <= vld[QB-1];
    if (adv) begin
      m.e <= sq.e;
      m.t <= ts;
      m.last <= !sq.e.flat || sq.second || !sq.e.emit_b;
      m.px <= 51'(tsg * dx);
      m.py <= 51'(tsg * dy);
      m.pu <= 51'(tsg * du);
      m.pv <= 51'(tsg * dv);
    end
  end

  function automatic logic [31:0] fin(input logic [31:0] a, input logic signed [50:0] p);
    logic signed [50:0] r;
    begin
      r = (p + 51'(1 << (TB - 1))) >>> TB;
      fin = a + r[31:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) oval <= 1'b0;
    else if (adv) oval <= mval;
    if (adv) begin
      odat.tri_id <= m.e.tri_id;
      odat.edge_idx <= m.e.edge_idx;
      odat.is_u <= m.e.is_u;
      odat.level <= m.e.level;
      odat.t <= m.t;
      odat.x <= fin(m.e.xa, m.px);
      odat.y <= fin(m.e.ya, m.py);
      odat.u <= fin(m.e.ua, m.pu);
      odat.v <= fin(m.e.va, m.pv);
      odat.last <= m.last;
    end
  end
  assign out_valid = oval;
  assign out_data = odat;

  snap_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.t <= iec_pkg::T_ONE) else $error("t above one");
  hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result lost");
  flat_ends: assert property (@(posedge clk) disable iff (rst)
    split_phase |-> in_valid) else $error("split dropped");
endmodule

>>> design/isoline_edge_crossing_top.sv
// Top level of the isoline edge crossing block.
// Usage: push one triangle edge per beat (push high, full low). Each edge gives
// zero, one or two crossing beats on the result side; last_of_item marks the
// final one. Results are read like a queue: while empty is low the oldest
// result is on the ports and pop takes it.
// From push to a result an edge passes one classify stage, a short
// queue, seventeen divider stages (one quotient bit each), a multiply stage
// and the output register. One edge is taken per cycle while full is low; an
// edge lying on the isoline with both ends in tolerance enters the divider as
// two beats. When pop stays low the back pipeline freezes, the queue fills and
// full rises. Reset clears all valid state and sets both tolerances to 1.
// Configuration: cfg_valid/cfg_ready with cfg_index 0 for coord_tolerance,
// 1 for t_snap_tolerance; cfg_ready is always high. Write only while idle.
`timescale 1ns / 1ps
module isoline_edge_crossing_top #(
  parameter int FRAC_BITS = iec_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic push,
  output logic full,
  input  logic [19:0] triangle_id,
  input  logic [1:0]  edge_index,
  input  logic        is_u_line,
  input  logic signed [15:0] iso_level,
  input  logic signed [31:0] ua, va, ub, vb, xa, ya, xb, yb,
  output logic empty,
  input  logic pop,
  output logic [19:0] out_triangle,
  output logic [1:0]  out_edge,
  output logic        out_is_u,
  output logic signed [15:0] out_level,
  output logic [16:0] edge_param,
  output logic signed [31:0] cross_x, cross_y, cross_u, cross_v,
  output logic last_of_item
);
  localparam int QD = iec_pkg::QUEUE_DEPTH;
  localparam int QA = $clog2(QD);
  logic [15:0] coord_tol, snap_limit;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      coord_tol <= 16'd1;
      snap_limit <= 16'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        iec_pkg::REG_COORD_TOL: coord_tol <= cfg_data;
        iec_pkg::REG_SNAP_TOL: snap_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  logic fv, fr, in_ready;
  iec_pkg::edge_cls_t fd;
  assign full = !in_ready;
  iec_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .in_valid(push), .in_ready, .coord_tol,
    .triangle_id, .edge_index, .is_u_line, .iso_level,
    .ua, .va, .ub, .vb, .xa, .ya, .xb, .yb,
    .q_valid(fv), .q_ready(fr), .q_data(fd));

  // Decoupling queue between front and back.
  iec_pkg::edge_cls_t mem [QD];
  logic [QA:0] wp, rp;
  logic qv, bready;
  logic [QA:0] cnt;
  assign cnt = wp - rp;
  assign fr = cnt != (QA + 1)'(QD);
  assign qv = cnt != '0;
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
    end else begin
      if (fv && fr) wp <= wp + 1'b1;
      if (qv && bready) rp <= rp + 1'b1;
    end
    if (fv && fr) mem[wp[QA-1:0]] <= fd;
  end

  iec_pkg::cross_t r;
  logic bv;
  iec_back u_back (
    .clk, .rst, .snap_limit, .in_valid(qv), .in_ready(bready),
    .in_data(mem[rp[QA-1:0]]), .out_valid(bv), .out_ready(pop), .out_data(r));
  assign empty = !bv;
  assign out_triangle = r.tri_id;
  assign out_edge = r.edge_idx;
  assign out_is_u = r.is_u;
  assign out_level = r.level;
  assign edge_param = r.t;
  assign cross_x = r.x;
  assign cross_y = r.y;
  assign cross_u = r.u;
  assign cross_v = r.v;
  assign last_of_item = r.last;

  q_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (QA + 1)'(QD)) else $error("queue overrun");
  q_push_full: assert property (@(posedge clk) disable iff (rst)
    !fr |-> !(cnt < (QA + 1)'(QD))) else $error("bad full");
  q_move: assert property (@(posedge clk) disable iff (rst)
    qv && bready |=> rp == $past(rp) + 1'b1) else $error("read lost");
endmodule
